/* rtl/ocrp_pkg.sv */
// ----------------------------------------------------------------------------
// ocrp_pkg
// Shared types, character codes and lookup functions for the colour reply
// parser: token format between front and back, status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ocrp_pkg;

   // control characters and printable codes that the parser looks for
   localparam logic [7:0] CH_BEL      = 8'h07;
   localparam logic [7:0] CH_ESC      = 8'h1b;
   localparam logic [7:0] CH_ST       = 8'h9c;
   localparam logic [7:0] CH_OSC      = 8'h9d;
   localparam logic [7:0] CH_RBRACKET = 8'h5d;
   localparam logic [7:0] CH_FOUR     = 8'h34;
   localparam logic [7:0] CH_SEMI     = 8'h3b;
   localparam logic [7:0] CH_BSLASH   = 8'h5c;
   localparam logic [7:0] CH_MINUS    = 8'h2d;
   localparam logic [7:0] CH_SLASH    = 8'h2f;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_LOW_R    = 8'h72;
   localparam logic [7:0] CH_LOW_G    = 8'h67;
   localparam logic [7:0] CH_LOW_B    = 8'h62;
   localparam logic [7:0] CH_COLON    = 8'h3a;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [1:0] ST_BAD_COLOR = 2'd2;

   // depth of the queue between front and back
   localparam int FIFO_DEPTH = 2;

   // token kinds passed from front to back
   typedef enum logic [1:0] {
      TK_BYTE   = 2'd0,  // one body byte
      TK_ESC    = 2'd1,  // a lone escape inside the body, nothing else
      TK_FINISH = 2'd2   // terminator seen, produce a result
   } tok_kind_type;

   // esc: a lone escape preceded this byte or terminator
   typedef struct packed {
      tok_kind_type kind;
      logic         esc;
      logic [7:0]   data;
   } token_type;

   // expected character of the colour space literal at a position
   function automatic logic [7:0] literal_char(input logic [1:0] pos);
      logic [7:0] ch;
      case (pos)
         2'd0:    ch = CH_LOW_R;
         2'd1:    ch = CH_LOW_G;
         2'd2:    ch = CH_LOW_B;
         default: ch = CH_COLON;
      endcase
      return ch;
   endfunction

   // hex digit decode: bit 4 set when the character is a hex digit
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end else begin
         r = 5'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/ocrp_if.sv */
// ----------------------------------------------------------------------------
// ocrp_if
// Valid/ready channel interfaces for terminal bytes in and parsed replies out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ocrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface ocrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] palette_index;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;

   modport source (output valid, output status, output palette_index,
                   output red, output green, output blue, input ready);
   modport sink   (input valid, input status, input palette_index,
                   input red, input green, input blue, output ready);
endinterface

`default_nettype wire

/* rtl/osc4_color_reply_parser_core.sv */
// ----------------------------------------------------------------------------
// osc4_color_reply_parser_core
// Parses OSC 4 palette colour replies from a terminal byte stream and
// returns one status/index/colour record per reply.
//
//   port      dir   carries
//   req_bus   in    one terminal byte per request (in_byte)
//   rsp_bus   out   status, palette_index, red, green, blue per reply
//
// One byte is taken every cycle while the token queue has room; the back
// end retires one token per cycle, stalling only on a terminator while the
// reply register still holds an untaken reply.
// With the queue empty, a terminator byte passes through a queue slot and
// then the reply register, where its reply is held until it is taken.
// Synchronous reset returns the front to introducer search and empties
// the queue and the reply register.
// ----------------------------------------------------------------------------
`default_nettype none

module osc4_color_reply_parser_core #(
   parameter int INDEX_BITS = 16
) (
   input  wire logic   clock,
   input  wire logic   reset,
   ocrp_req_if.sink    req_bus,
   ocrp_rsp_if.source  rsp_bus
);

   logic                front_valid, front_ready;
   ocrp_pkg::token_type front_tok;
   logic                back_valid, back_ready;
   ocrp_pkg::token_type back_tok;

   // introducer search and terminator detection
   ocrp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_byte  (req_bus.in_byte),
      .req_ready (req_bus.ready),
      .tok_valid (front_valid),
      .tok       (front_tok),
      .tok_ready (front_ready)
   );

   // token queue
   ocrp_token_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_token  (front_tok),
      .in_ready  (front_ready),
      .out_valid (back_valid),
      .out_token (back_tok),
      .out_ready (back_ready)
   );

   // body parser and reply register
   ocrp_back #(
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .tok_valid         (back_valid),
      .tok               (back_tok),
      .tok_ready         (back_ready),
      .rsp_valid         (rsp_bus.valid),
      .rsp_status        (rsp_bus.status),
      .rsp_palette_index (rsp_bus.palette_index),
      .rsp_red           (rsp_bus.red),
      .rsp_green         (rsp_bus.green),
      .rsp_blue          (rsp_bus.blue),
      .rsp_ready         (rsp_bus.ready)
   );

endmodule

`default_nettype wire

/* rtl/ocrp_front.sv */
// ----------------------------------------------------------------------------
// ocrp_front
// Introducer hunter and terminator detector. Turns raw bytes into body
// tokens for the back end; drops everything outside a reply body.
// ----------------------------------------------------------------------------
`default_nettype none

module ocrp_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic [7:0]           req_byte,
   output logic                      req_ready,
   output logic                      tok_valid,
   output ocrp_pkg::token_type       tok,
   input  wire logic                 tok_ready
);

   typedef enum logic [5:0] {
      HS_HUNT   = 6'b000001,
      HS_ESC1   = 6'b000010,
      HS_ESC2   = 6'b000100,
      HS_NINE_D = 6'b001000,
      HS_FOUR   = 6'b010000,
      HS_BODY   = 6'b100000
   } hunt_state_type;

   hunt_state_type state_ff, state_in;
   logic           pending_ff, pending_in;
   logic           emit;
   logic           accept;

   // a byte is taken whenever the queue has room
   assign req_ready = tok_ready;
   assign accept    = req_valid && tok_ready;
   assign tok_valid = req_valid && emit;

   // classify the byte
   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      emit       = 1'b0;
      tok.kind   = ocrp_pkg::TK_BYTE;
      tok.esc    = 1'b0;
      tok.data   = req_byte;
      case (state_ff)
         HS_BODY: begin
            if (pending_ff) begin
               pending_in = 1'b0;
               emit       = 1'b1;
               if (req_byte == ocrp_pkg::CH_BSLASH) begin
                  tok.kind = ocrp_pkg::TK_FINISH;
                  state_in = HS_HUNT;
               end else if (req_byte == ocrp_pkg::CH_BEL || req_byte == ocrp_pkg::CH_ST) begin
                  tok.kind = ocrp_pkg::TK_FINISH;
                  tok.esc  = 1'b1;
                  state_in = HS_HUNT;
               end else if (req_byte == ocrp_pkg::CH_ESC) begin
                  tok.kind   = ocrp_pkg::TK_ESC;
                  pending_in = 1'b1;
               end else begin
                  tok.esc = 1'b1;
               end
            end else if (req_byte == ocrp_pkg::CH_BEL || req_byte == ocrp_pkg::CH_ST) begin
               emit     = 1'b1;
               tok.kind = ocrp_pkg::TK_FINISH;
               state_in = HS_HUNT;
            end else if (req_byte == ocrp_pkg::CH_ESC) begin
               pending_in = 1'b1;
            end else begin
               emit = 1'b1;
            end
         end
         default: begin
            // introducer search; a breaking byte may start a new introducer
            if (state_ff == HS_ESC1 && req_byte == ocrp_pkg::CH_RBRACKET) begin
               state_in = HS_ESC2;
            end else if ((state_ff == HS_ESC2 || state_ff == HS_NINE_D)
                         && req_byte == ocrp_pkg::CH_FOUR) begin
               state_in = HS_FOUR;
            end else if (state_ff == HS_FOUR && req_byte == ocrp_pkg::CH_SEMI) begin
               state_in   = HS_BODY;
               pending_in = 1'b0;
            end else if (req_byte == ocrp_pkg::CH_ESC) begin
               state_in = HS_ESC1;
            end else if (req_byte == ocrp_pkg::CH_OSC) begin
               state_in = HS_NINE_D;
            end else begin
               state_in = HS_HUNT;
            end
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= HS_HUNT;
         pending_ff <= 1'b0;
      end else if (accept) begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/ocrp_token_fifo.sv */
// ----------------------------------------------------------------------------
// ocrp_token_fifo
// Short token queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module ocrp_token_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire ocrp_pkg::token_type  in_token,
   output logic                      in_ready,
   output logic                      out_valid,
   output ocrp_pkg::token_type       out_token,
   input  wire logic                 out_ready
);

   localparam int PTR_BITS = (ocrp_pkg::FIFO_DEPTH > 1) ? $clog2(ocrp_pkg::FIFO_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(ocrp_pkg::FIFO_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(ocrp_pkg::FIFO_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(ocrp_pkg::FIFO_DEPTH);
   localparam logic [PTR_BITS-1:0] PTR_ONE  = PTR_BITS'(1);
   localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);

   ocrp_pkg::token_type slots_ff [ocrp_pkg::FIFO_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                push, pop;

   assign in_ready  = (count_ff != FULL_CNT);
   assign out_valid = (count_ff != '0);
   assign out_token = slots_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_token;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_ONE;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_ONE;
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_ONE;
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_ONE;
         end
      end
   end

   // fill count never passes the depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("token queue overfilled");

   // empty or full queue has matching pointers
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_CNT) |-> (rd_ptr_ff == wr_ptr_ff))
      else $error("token queue pointers out of step");

   // a token written into an empty queue is offered next cycle
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 && push) |=> out_valid && out_token == $past(in_token))
      else $error("token lost in queue");

endmodule

`default_nettype wire

/* rtl/ocrp_back.sv */
// ----------------------------------------------------------------------------
// ocrp_back
// Body parser: index, colour space literal and three hex channels. Builds
// one reply per terminator token into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ocrp_back #(
   parameter int INDEX_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 tok_valid,
   input  wire ocrp_pkg::token_type  tok,
   output logic                      tok_ready,
   output logic                      rsp_valid,
   output logic [1:0]                rsp_status,
   output logic [15:0]               rsp_palette_index,
   output logic [7:0]                rsp_red,
   output logic [7:0]                rsp_green,
   output logic [7:0]                rsp_blue,
   input  wire logic                 rsp_ready
);

   typedef enum logic [3:0] {
      PH_INDEX   = 4'b0001,
      PH_LITERAL = 4'b0010,
      PH_CHANNEL = 4'b0100,
      PH_SKIP    = 4'b1000
   } phase_type;

   localparam int PROD_BITS = INDEX_BITS + 4;

   phase_type              phase_ff, phase_in, phase_a;
   logic [1:0]             error_ff, error_in, error_a;
   logic [INDEX_BITS-1:0]  idx_ff, idx_in;
   logic                   digit_seen_ff, digit_seen_in;
   logic                   minus_ff, minus_in;
   logic                   over_ff, over_in;
   logic [1:0]             lit_pos_ff, lit_pos_in;
   logic [1:0]             chan_num_ff, chan_num_in;
   logic [2:0]             dig_cnt_ff, dig_cnt_in;
   logic [7:0]             top_nib_ff, top_nib_in;
   logic [15:0]            saved_ff, saved_in;

   logic                   rsp_valid_ff;
   logic [1:0]             status_ff;
   logic [15:0]            pal_ff;
   logic [7:0]             red_ff, green_ff, blue_ff;

   logic                   out_free, pop, finish;
   logic [PROD_BITS-1:0]   idx_prod;
   logic [4:0]             hex;
   logic                   chan_ok;
   logic [7:0]             chan_byte;
   logic [1:0]             status_c;
   logic [INDEX_BITS+15:0] idx_ext;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign tok_ready = (tok.kind != ocrp_pkg::TK_FINISH) || out_free;
   assign pop       = tok_valid && tok_ready;
   assign finish    = pop && (tok.kind == ocrp_pkg::TK_FINISH);

   // index times ten plus digit
   assign idx_prod = {1'b0, idx_ff, 3'b000} + {3'b000, idx_ff, 1'b0}
                   + {{(PROD_BITS-4){1'b0}}, tok.data[3:0]};
   assign hex      = ocrp_pkg::hex_decode(tok.data);

   // channel byte from gathered digits
   assign chan_ok   = (dig_cnt_ff >= 3'd1) && (dig_cnt_ff <= 3'd4);
   assign chan_byte = (dig_cnt_ff == 3'd1) ? {top_nib_ff[3:0], top_nib_ff[3:0]} : top_nib_ff;

   // a lone escape faults the body where it stands
   always_comb begin
      phase_a = phase_ff;
      error_a = error_ff;
      if (tok.esc || tok.kind == ocrp_pkg::TK_ESC) begin
         case (phase_ff)
            PH_INDEX: begin
               phase_a = PH_SKIP;
               if (error_ff == ocrp_pkg::ST_OK) error_a = ocrp_pkg::ST_BAD_INDEX;
            end
            PH_LITERAL, PH_CHANNEL: begin
               phase_a = PH_SKIP;
               if (error_ff == ocrp_pkg::ST_OK) error_a = ocrp_pkg::ST_BAD_COLOR;
            end
            default: ;
         endcase
      end
   end

   // body byte parsing
   always_comb begin
      phase_in      = phase_a;
      error_in      = error_a;
      idx_in        = idx_ff;
      digit_seen_in = digit_seen_ff;
      minus_in      = minus_ff;
      over_in       = over_ff;
      lit_pos_in    = lit_pos_ff;
      chan_num_in   = chan_num_ff;
      dig_cnt_in    = dig_cnt_ff;
      top_nib_in    = top_nib_ff;
      saved_in      = saved_ff;
      if (tok.kind == ocrp_pkg::TK_BYTE) begin
         case (phase_a)
            PH_INDEX: begin
               if (tok.data == ocrp_pkg::CH_SEMI) begin
                  if (!digit_seen_ff || over_ff || (minus_ff && idx_ff != '0)) begin
                     phase_in = PH_SKIP;
                     if (error_a == ocrp_pkg::ST_OK) error_in = ocrp_pkg::ST_BAD_INDEX;
                  end else begin
                     phase_in   = PH_LITERAL;
                     lit_pos_in = 2'd0;
                  end
               end else if (tok.data == ocrp_pkg::CH_MINUS && !digit_seen_ff
                            && !minus_ff && !over_ff) begin
                  minus_in = 1'b1;
               end else if (tok.data >= ocrp_pkg::CH_ZERO && tok.data <= ocrp_pkg::CH_NINE) begin
                  digit_seen_in = 1'b1;
                  if (idx_prod[PROD_BITS-1:INDEX_BITS] != '0) begin
                     over_in = 1'b1;
                     idx_in  = '1;
                  end else begin
                     idx_in = idx_prod[INDEX_BITS-1:0];
                  end
               end else begin
                  phase_in = PH_SKIP;
                  if (error_a == ocrp_pkg::ST_OK) error_in = ocrp_pkg::ST_BAD_INDEX;
               end
            end
            PH_LITERAL: begin
               if (tok.data != ocrp_pkg::literal_char(lit_pos_ff)) begin
                  phase_in = PH_SKIP;
                  if (error_a == ocrp_pkg::ST_OK) error_in = ocrp_pkg::ST_BAD_COLOR;
               end else if (lit_pos_ff == 2'd3) begin
                  phase_in    = PH_CHANNEL;
                  chan_num_in = 2'd0;
                  dig_cnt_in  = 3'd0;
                  top_nib_in  = 8'd0;
               end else begin
                  lit_pos_in = lit_pos_ff + 2'd1;
               end
            end
            PH_CHANNEL: begin
               if (tok.data == ocrp_pkg::CH_SLASH) begin
                  if (chan_num_ff >= 2'd2 || !chan_ok) begin
                     phase_in = PH_SKIP;
                     if (error_a == ocrp_pkg::ST_OK) error_in = ocrp_pkg::ST_BAD_COLOR;
                  end else begin
                     saved_in    = {saved_ff[7:0], chan_byte};
                     chan_num_in = chan_num_ff + 2'd1;
                     dig_cnt_in  = 3'd0;
                     top_nib_in  = 8'd0;
                  end
               end else if (hex[4]) begin
                  if (dig_cnt_ff < 3'd2) top_nib_in = {top_nib_ff[3:0], hex[3:0]};
                  if (dig_cnt_ff < 3'd5) dig_cnt_in = dig_cnt_ff + 3'd1;
               end else begin
                  phase_in = PH_SKIP;
                  if (error_a == ocrp_pkg::ST_OK) error_in = ocrp_pkg::ST_BAD_COLOR;
               end
            end
            default: ;
         endcase
      end
   end

   // status at the terminator
   always_comb begin
      case (phase_a)
         PH_INDEX:   status_c = ocrp_pkg::ST_BAD_INDEX;
         PH_LITERAL: status_c = ocrp_pkg::ST_BAD_COLOR;
         PH_CHANNEL: status_c = (chan_num_ff != 2'd2 || !chan_ok) ? ocrp_pkg::ST_BAD_COLOR
                                                                  : ocrp_pkg::ST_OK;
         default:    status_c = error_a;
      endcase
   end

   assign idx_ext = {16'd0, idx_ff};

   // parser state; a terminator readies it for the next body
   always_ff @(posedge clock) begin
      if (reset || finish) begin
         phase_ff      <= PH_INDEX;
         error_ff      <= ocrp_pkg::ST_OK;
         idx_ff        <= '0;
         digit_seen_ff <= 1'b0;
         minus_ff      <= 1'b0;
         over_ff       <= 1'b0;
         lit_pos_ff    <= 2'd0;
         chan_num_ff   <= 2'd0;
         dig_cnt_ff    <= 3'd0;
         top_nib_ff    <= 8'd0;
         saved_ff      <= 16'd0;
      end else if (pop) begin
         phase_ff      <= phase_in;
         error_ff      <= error_in;
         idx_ff        <= idx_in;
         digit_seen_ff <= digit_seen_in;
         minus_ff      <= minus_in;
         over_ff       <= over_in;
         lit_pos_ff    <= lit_pos_in;
         chan_num_ff   <= chan_num_in;
         dig_cnt_ff    <= dig_cnt_in;
         top_nib_ff    <= top_nib_in;
         saved_ff      <= saved_in;
      end
   end

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output payload, zero on any fault
   always_ff @(posedge clock) begin
      if (finish) begin
         status_ff <= status_c;
         if (status_c == ocrp_pkg::ST_OK) begin
            pal_ff   <= idx_ext[15:0];
            red_ff   <= saved_ff[15:8];
            green_ff <= saved_ff[7:0];
            blue_ff  <= chan_byte;
         end else begin
            pal_ff   <= 16'd0;
            red_ff   <= 8'd0;
            green_ff <= 8'd0;
            blue_ff  <= 8'd0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_palette_index = pal_ff;
   assign rsp_red           = red_ff;
   assign rsp_green         = green_ff;
   assign rsp_blue          = blue_ff;

   // a faulted body keeps its error code
   a_skip_has_error: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) |-> (error_ff != ocrp_pkg::ST_OK))
      else $error("skip phase without an error code");

   // every reply leaves the parser ready for a fresh index
   a_finish_restarts: assert property (@(posedge clock) disable iff (reset)
      finish |=> (phase_ff == PH_INDEX && error_ff == ocrp_pkg::ST_OK && !digit_seen_ff))
      else $error("parser not cleared after reply");

   // a faulted reply carries no colour
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != ocrp_pkg::ST_OK)
      |-> (pal_ff == 16'd0 && red_ff == 8'd0 && green_ff == 8'd0 && blue_ff == 8'd0))
      else $error("faulted reply carries data");

endmodule

`default_nettype wire

/* sim/tb_osc4_color_reply_parser_core.sv */
// ----------------------------------------------------------------------------
// tb_osc4_color_reply_parser_core
// Self-checking bench for the OSC 4 colour reply parser. A byte-level model
// of the parser runs on every accepted request and queues the reply it
// should produce. Replies taken from the block are checked field by field
// against that queue. A short directed stream covers the edge cases. It is
// followed by random replies, some clean and some mangled, mixed with line
// noise, under several patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------

module tb_osc4_color_reply_parser_core;

   localparam int          IDX_BITS    = 16;
   localparam logic [63:0] IDX_LIMIT   = (64'd1 << IDX_BITS) - 64'd1;
   localparam int          PHASE_BYTES = 400;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          TAIL_CYCLES = 10;
   localparam int          SEND_IDLE  [4] = '{0, 73, 0, 30};
   localparam int          RECV_STALL [4] = '{0, 0, 73, 30};
   localparam logic [7:0]  RGB_TEXT   [4] = '{ocrp_pkg::CH_LOW_R, ocrp_pkg::CH_LOW_G,
                                              ocrp_pkg::CH_LOW_B, ocrp_pkg::CH_COLON};
   localparam string       HEX_DIGITS = "0123456789abcdefABCDEF";

   typedef enum logic [3:0] {
      P_HUNT, P_ESC1, P_ESC2, P_NINE_D, P_FOUR,
      P_INDEX, P_LITERAL, P_CHANNEL, P_SKIP
   } parse_phase_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] palette_index;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } color_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ocrp_req_if req_bus ();
   ocrp_rsp_if rsp_bus ();

   osc4_color_reply_parser_core #(
      .INDEX_BITS (IDX_BITS)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // stimulus and checking state
   logic [7:0]      bytes_to_send [$];
   logic [7:0]      reply_buf [$];
   color_reply_type replies_due [$];
   int              idle_pct       = 0;
   int              stall_pct      = 0;
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   bit              req_taken      = 1'b0;

   // parser model state
   parse_phase_type parse_state;
   bit              esc_held;
   logic [31:0]     idx_val;
   bit              idx_digit;
   bit              idx_minus;
   bit              idx_over;
   logic [2:0]      lit_pos;
   logic [1:0]      chan_num;
   logic [2:0]      dig_cnt;
   logic [7:0]      top_nib;
   logic [15:0]     saved_rg;
   logic [1:0]      err_code;

   always #10 clock = ~clock;

   // append one byte to the reply being built
   task automatic buf_byte(input logic [7:0] b);
      reply_buf.insert(reply_buf.size(), b);
   endtask

   // append one byte to the send queue
   task automatic queue_byte(input logic [7:0] b);
      bytes_to_send.insert(bytes_to_send.size(), b);
   endtask

   // ------------------------------------------------------------------------
   // parser model
   // ------------------------------------------------------------------------

   // hex digit value, bit 4 flags a valid digit
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= ocrp_pkg::CH_ZERO && c <= ocrp_pkg::CH_NINE) begin
         d = c - ocrp_pkg::CH_ZERO;
      end else if (c >= "a" && c <= "f") begin
         d = c - "a" + 8'd10;
      end else if (c >= "A" && c <= "F") begin
         d = c - "A" + 8'd10;
      end else begin
         return 5'd0;
      end
      return {1'b1, d[3:0]};
   endfunction

   // byte of the channel being gathered, bit 8 clear on a bad digit count
   function automatic logic [8:0] chan_value();
      if (dig_cnt == 3'd1) begin
         return {1'b1, top_nib[3:0], top_nib[3:0]};
      end else if (dig_cnt >= 3'd2 && dig_cnt <= 3'd4) begin
         return {1'b1, top_nib};
      end
      return 9'd0;
   endfunction

   task automatic open_body();
      parse_state = P_INDEX;
      esc_held    = 1'b0;
      idx_val     = '0;
      idx_digit   = 1'b0;
      idx_minus   = 1'b0;
      idx_over    = 1'b0;
      lit_pos     = '0;
      chan_num    = '0;
      dig_cnt     = '0;
      top_nib     = '0;
      saved_rg    = '0;
      err_code    = ocrp_pkg::ST_OK;
   endtask

   // first fault sets the status, the rest of the body is skipped
   task automatic set_fault(input logic [1:0] code);
      if (err_code == ocrp_pkg::ST_OK) begin
         err_code = code;
      end
      parse_state = P_SKIP;
   endtask

   // introducer search; a breaking byte may start a new introducer
   task automatic hunt_byte(input logic [7:0] c);
      if (parse_state == P_ESC1 && c == ocrp_pkg::CH_RBRACKET) begin
         parse_state = P_ESC2;
      end else if ((parse_state == P_ESC2 || parse_state == P_NINE_D)
                   && c == ocrp_pkg::CH_FOUR) begin
         parse_state = P_FOUR;
      end else if (parse_state == P_FOUR && c == ocrp_pkg::CH_SEMI) begin
         open_body();
      end else if (c == ocrp_pkg::CH_ESC) begin
         parse_state = P_ESC1;
      end else if (c == ocrp_pkg::CH_OSC) begin
         parse_state = P_NINE_D;
      end else begin
         parse_state = P_HUNT;
      end
   endtask

   task automatic body_byte(input logic [7:0] c);
      logic [63:0] wide;
      logic [8:0]  cb;
      logic [4:0]  hv;
      hv = hex_nibble(c);
      case (parse_state)
         // decimal index up to the semicolon
         P_INDEX: begin
            if (c == ocrp_pkg::CH_SEMI) begin
               if (!idx_digit || idx_over || (idx_minus && idx_val != 0)) begin
                  set_fault(ocrp_pkg::ST_BAD_INDEX);
               end else begin
                  parse_state = P_LITERAL;
                  lit_pos     = '0;
               end
            end else if (c == ocrp_pkg::CH_MINUS && !idx_digit && !idx_minus
                         && !idx_over) begin
               idx_minus = 1'b1;
            end else if (c >= ocrp_pkg::CH_ZERO && c <= ocrp_pkg::CH_NINE) begin
               wide      = 64'(idx_val) * 64'd10 + 64'(c - ocrp_pkg::CH_ZERO);
               idx_digit = 1'b1;
               if (wide > IDX_LIMIT) begin
                  idx_over = 1'b1;
                  wide     = IDX_LIMIT;
               end
               idx_val = wide[31:0];
            end else begin
               set_fault(ocrp_pkg::ST_BAD_INDEX);
            end
         end
         // colour space literal
         P_LITERAL: begin
            if (lit_pos > 3'd3 || c != RGB_TEXT[lit_pos[1:0]]) begin
               set_fault(ocrp_pkg::ST_BAD_COLOR);
            end else begin
               lit_pos = lit_pos + 3'd1;
               if (lit_pos == 3'd4) begin
                  parse_state = P_CHANNEL;
                  chan_num    = '0;
                  dig_cnt     = '0;
                  top_nib     = '0;
               end
            end
         end
         // hex channels split by slashes
         P_CHANNEL: begin
            if (c == ocrp_pkg::CH_SLASH) begin
               cb = chan_value();
               if (chan_num >= 2'd2 || !cb[8]) begin
                  set_fault(ocrp_pkg::ST_BAD_COLOR);
               end else begin
                  saved_rg = {saved_rg[7:0], cb[7:0]};
                  chan_num = chan_num + 2'd1;
                  dig_cnt  = '0;
                  top_nib  = '0;
               end
            end else if (hv[4]) begin
               if (dig_cnt < 3'd2) begin
                  top_nib = {top_nib[3:0], hv[3:0]};
               end
               if (dig_cnt < 3'd5) begin
                  dig_cnt = dig_cnt + 3'd1;
               end
            end else begin
               set_fault(ocrp_pkg::ST_BAD_COLOR);
            end
         end
         default: ;
      endcase
   endtask

   // terminator: work out the reply and go back to hunting
   task automatic close_reply();
      color_reply_type rec;
      logic [8:0]      cb;
      rec = '0;
      cb  = chan_value();
      case (parse_state)
         P_INDEX:   rec.status = ocrp_pkg::ST_BAD_INDEX;
         P_LITERAL: rec.status = ocrp_pkg::ST_BAD_COLOR;
         P_CHANNEL: begin
            if (chan_num != 2'd2 || !cb[8]) begin
               rec.status = ocrp_pkg::ST_BAD_COLOR;
            end else begin
               rec.status = ocrp_pkg::ST_OK;
               rec.blue   = cb[7:0];
            end
         end
         default:   rec.status = err_code;
      endcase
      if (rec.status == ocrp_pkg::ST_OK) begin
         rec.palette_index = idx_val[15:0];
         rec.red           = saved_rg[15:8];
         rec.green         = saved_rg[7:0];
      end
      replies_due.insert(replies_due.size(), rec);
      parse_state = P_HUNT;
      esc_held    = 1'b0;
   endtask

   // one accepted request through the model
   task automatic parse_byte(input logic [7:0] c);
      if (parse_state < P_INDEX) begin
         hunt_byte(c);
      end else if (esc_held && c == ocrp_pkg::CH_BSLASH) begin
         close_reply();
      end else begin
         // an escape not followed by backslash is an ordinary body byte
         if (esc_held) begin
            esc_held = 1'b0;
            body_byte(ocrp_pkg::CH_ESC);
         end
         if (c == ocrp_pkg::CH_BEL || c == ocrp_pkg::CH_ST) begin
            close_reply();
         end else if (c == ocrp_pkg::CH_ESC) begin
            esc_held = 1'b1;
         end else begin
            body_byte(c);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // stimulus builders
   // ------------------------------------------------------------------------

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         buf_byte(s[i]);
      end
   endtask

   task automatic put_intro(input bit eight_bit);
      if (eight_bit) begin
         buf_byte(ocrp_pkg::CH_OSC);
      end else begin
         buf_byte(ocrp_pkg::CH_ESC);
         buf_byte(ocrp_pkg::CH_RBRACKET);
      end
      buf_byte(ocrp_pkg::CH_FOUR);
      buf_byte(ocrp_pkg::CH_SEMI);
   endtask

   // backslash as terminator stands for the escape backslash pair
   task automatic put_term(input logic [7:0] term);
      if (term == ocrp_pkg::CH_BSLASH) begin
         buf_byte(ocrp_pkg::CH_ESC);
      end
      buf_byte(term);
   endtask

   task automatic flush_reply();
      foreach (reply_buf[i]) begin
         queue_byte(reply_buf[i]);
      end
      reply_buf.delete();
   endtask

   task automatic send_reply(input bit eight_bit, input string body, input logic [7:0] term);
      put_intro(eight_bit);
      put_text(body);
      put_term(term);
      flush_reply();
   endtask

   // one corrupted byte somewhere after the introducer
   task automatic mangle_reply(input int unsigned first);
      int unsigned k;
      k = $urandom_range(reply_buf.size() - 1, first);
      case ($urandom_range(3))
         0:       reply_buf[k] = 8'($urandom_range(255));
         1:       reply_buf.delete(k);
         2:       reply_buf.insert(k, ocrp_pkg::CH_ESC);
         default: reply_buf.insert(k, 8'($urandom_range(255)));
      endcase
   endtask

   task automatic add_random_reply();
      int unsigned first;
      int unsigned n_ch;
      int unsigned n_dig;
      string       txt;
      // introducer, sometimes behind a partial one
      case ($urandom_range(5))
         0: put_intro(1'b1);
         1: begin
            buf_byte(ocrp_pkg::CH_ESC);
            put_intro(1'b0);
         end
         2: begin
            buf_byte(ocrp_pkg::CH_OSC);
            put_intro(1'b1);
         end
         3: begin
            buf_byte(ocrp_pkg::CH_ESC);
            buf_byte(ocrp_pkg::CH_RBRACKET);
            put_intro(1'b0);
         end
         default: put_intro(1'b0);
      endcase
      first = reply_buf.size();
      // palette index
      case ($urandom_range(9))
         0:       txt = "0";
         1:       txt = "-0";
         2:       txt = $sformatf("-%0d", $urandom_range(9999, 1));
         3:       txt = $sformatf("%0d", $urandom_range(99999, 65536));
         4:       txt = $sformatf("%0d%0d", $urandom, $urandom);
         5:       txt = $sformatf("00%0d", $urandom_range(255));
         6:       txt = $sformatf("%0d", $urandom_range(65535, 60000));
         default: txt = $sformatf("%0d", $urandom_range(255));
      endcase
      put_text(txt);
      put_text(";rgb:");
      // colour channels, now and then a wrong count of channels or digits
      n_ch = ($urandom_range(15) == 0) ? ($urandom_range(1) ? 2 : 4) : 3;
      for (int i = 0; i < n_ch; i++) begin
         if (i != 0) begin
            buf_byte(ocrp_pkg::CH_SLASH);
         end
         n_dig = ($urandom_range(19) == 0) ? ($urandom_range(1) ? 0 : 5)
                                           : $urandom_range(4, 1);
         for (int j = 0; j < n_dig; j++) begin
            buf_byte(HEX_DIGITS[$urandom_range(21)]);
         end
      end
      case ($urandom_range(2))
         0:       put_term(ocrp_pkg::CH_BEL);
         1:       put_term(ocrp_pkg::CH_ST);
         default: put_term(ocrp_pkg::CH_BSLASH);
      endcase
      if ($urandom_range(3) == 0) begin
         mangle_reply(first);
      end
      flush_reply();
   endtask

   task automatic add_noise();
      repeat ($urandom_range(6, 1)) begin
         queue_byte(8'($urandom_range(255)));
      end
   endtask

   // edge cases: extremes, every terminator, index and body faults
   task automatic add_directed();
      queue_byte(8'h00);
      queue_byte(8'hff);
      queue_byte(ocrp_pkg::CH_BEL);
      queue_byte(ocrp_pkg::CH_ESC);
      queue_byte(ocrp_pkg::CH_RBRACKET);
      queue_byte(ocrp_pkg::CH_ST);
      send_reply(1'b0, "0;rgb:f/0/A", ocrp_pkg::CH_BEL);
      send_reply(1'b1, "65535;rgb:ffff/1234/aBcD", ocrp_pkg::CH_ST);
      queue_byte(ocrp_pkg::CH_ESC);
      send_reply(1'b0, "-0;rgb:00/FF/9", ocrp_pkg::CH_BSLASH);
      queue_byte(ocrp_pkg::CH_OSC);
      send_reply(1'b1, "00042;rgb:1/22/333", ocrp_pkg::CH_BEL);
      send_reply(1'b0, "65536;rgb:1/2/3", ocrp_pkg::CH_BEL);
      send_reply(1'b1, "-5;rgb:1/2/3", ocrp_pkg::CH_BEL);
      send_reply(1'b0, ";rgb:1/2/3", ocrp_pkg::CH_ST);
      send_reply(1'b0, "--0;rgb:1/2/3", ocrp_pkg::CH_BEL);
      send_reply(1'b0, "1-2;rgb:1/2/3", ocrp_pkg::CH_BEL);
      send_reply(1'b1, "12", ocrp_pkg::CH_BEL);
      send_reply(1'b0, "7;rgx:1/2/3", ocrp_pkg::CH_BEL);
      send_reply(1'b0, "7;rgb", ocrp_pkg::CH_BSLASH);
      send_reply(1'b0, "7;rgb:12345/1/1", ocrp_pkg::CH_BEL);
      send_reply(1'b0, "7;rgb:/1/1", ocrp_pkg::CH_ST);
      send_reply(1'b0, "7;rgb:1/2/3/4", ocrp_pkg::CH_BEL);
      send_reply(1'b0, "7;rgb:1/2", ocrp_pkg::CH_BSLASH);
      send_reply(1'b0, "7;rgb:1/g/2", ocrp_pkg::CH_BEL);
      send_reply(1'b0, "7;rgb:1/2\033]4;/3", ocrp_pkg::CH_BEL);
      send_reply(1'b1, "9\2354;rgb:1/2/3", ocrp_pkg::CH_BEL);
      send_reply(1'b0, "x;rgbQ", ocrp_pkg::CH_BEL);
   endtask

   // sender holds off until every reply due has been taken
   task automatic wait_drained();
      while (bytes_to_send.size() != 0 || req_bus.valid || replies_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   // ------------------------------------------------------------------------
   // driver, receiver and monitor
   // ------------------------------------------------------------------------

   // request driver and reply receiver, both on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (bytes_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_bus.in_byte <= bytes_to_send.pop_front();
            req_bus.valid   <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // monitor: check replies, feed accepted requests to the model
   always @(posedge clock) begin : monitor
      color_reply_type want;
      req_taken   <= req_bus.valid && req_bus.ready;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (replies_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: reply with none expected, actual status %0d index 0x%0h",
                        $time, rsp_bus.status, rsp_bus.palette_index);
            end else begin
               want = replies_due.pop_front();
               check_field("status", want.status, rsp_bus.status);
               check_field("palette_index", want.palette_index, rsp_bus.palette_index);
               check_field("red", want.red, rsp_bus.red);
               check_field("green", want.green, rsp_bus.green);
               check_field("blue", want.blue, rsp_bus.blue);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            parse_byte(req_bus.in_byte);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      req_bus.valid   = 1'b0;
      req_bus.in_byte = 8'd0;
      rsp_bus.ready   = 1'b0;
      open_body();
      parse_state = P_HUNT;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_directed();
      wait_drained();

      // random replies and noise, one idling pattern per phase
      for (int p = 0; p < 4; p++) begin
         idle_pct  = SEND_IDLE[p];
         stall_pct = RECV_STALL[p];
         while (bytes_to_send.size() < PHASE_BYTES) begin
            if ($urandom_range(4) == 0) begin
               add_noise();
            end else begin
               add_random_reply();
            end
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && replies_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
